// ===== rtl/bs_pkg.sv =====
// ----------------------------------------------------------------------------
// bs_pkg: shared definitions for the bounded stepper
// Widths, operation codes, register indexes and reset values used by the
// stepper sequencer and its serial remainder unit.
// ----------------------------------------------------------------------------
package bs_pkg;

  // Width of the held value, the step size and every range end.
  localparam int VAL_W  = 32;
  // Width of a move sum before bounding.
  localparam int WIDE_W = 64;
  // Width of the wrap span, which reaches 2^32 for the full range.
  localparam int SPAN_W = VAL_W + 1;
  // Width of the operation selector and of the register index.
  localparam int OP_W       = 2;
  localparam int CFG_ADDR_W = 2;

  localparam logic signed [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] INT_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum logic [OP_W-1:0] {
    OP_READ = 2'd0,
    OP_SET  = 2'd1,
    OP_MOVE = 2'd2,
    OP_STEP = 2'd3
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RANGE_MIN = 2'd0,
    REG_RANGE_MAX = 2'd1,
    REG_WRAP_MODE = 2'd2
  } cfg_reg_t;

endpackage

// ===== rtl/bs_mod_unit.sv =====
// ----------------------------------------------------------------------------
// bs_mod_unit: serial inclusive wrap
// Returns lo + ((value - lo) mod span) with a non-negative remainder, using a
// restoring remainder loop that retires one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bs_mod_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [bs_pkg::WIDE_W-1:0]    value,
  input  logic signed [bs_pkg::VAL_W-1:0]     lo,
  input  logic        [bs_pkg::SPAN_W-1:0]    span,
  output logic                                done,
  output logic signed [bs_pkg::VAL_W-1:0]     result
);
  import bs_pkg::*;

  localparam int CNT_W = $clog2(WIDE_W);

  typedef enum logic [2:0] {S_IDLE, S_SUB, S_ABS, S_ITER, S_FIX} state_t;

  state_t                    state_r;
  logic signed [WIDE_W-1:0]  value_r;
  logic signed [VAL_W-1:0]   lo_r;
  logic        [SPAN_W-1:0]  span_r;
  logic        [WIDE_W:0]    diff_r;
  logic        [WIDE_W-1:0]  mag_r;
  logic                      neg_r;
  logic        [VAL_W-1:0]   rem_r;
  logic        [CNT_W-1:0]   cnt_r;
  logic                      done_r;
  logic signed [VAL_W-1:0]   result_r;

  logic [WIDE_W:0]   diff_neg;
  logic [SPAN_W-1:0] rem_sh;
  logic [SPAN_W-1:0] rem_sub;
  logic [VAL_W-1:0]  rem_nxt;
  logic [SPAN_W-1:0] rem_fix;
  logic [VAL_W-1:0]  result_nxt;

  // One remainder step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh   = {rem_r, mag_r[WIDE_W-1]};
  assign rem_sub  = rem_sh - span_r;
  assign rem_nxt  = (rem_sh >= span_r) ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
  assign diff_neg = (~diff_r) + {{WIDE_W{1'b0}}, 1'b1};

  // A negative dividend leaves span - rem as the non-negative remainder.
  assign rem_fix    = (neg_r && (rem_r != '0)) ? (span_r - {1'b0, rem_r})
                                               : {1'b0, rem_r};
  assign result_nxt = lo_r + rem_fix[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            value_r <= value;
            lo_r    <= lo;
            span_r  <= span;
            state_r <= S_SUB;
          end
        end
        S_SUB: begin
          diff_r  <= {value_r[WIDE_W-1], value_r}
                     - {{(WIDE_W+1-VAL_W){lo_r[VAL_W-1]}}, lo_r};
          state_r <= S_ABS;
        end
        S_ABS: begin
          neg_r   <= diff_r[WIDE_W];
          mag_r   <= diff_r[WIDE_W] ? diff_neg[WIDE_W-1:0] : diff_r[WIDE_W-1:0];
          rem_r   <= '0;
          cnt_r   <= CNT_W'(WIDE_W - 1);
          state_r <= S_ITER;
        end
        S_ITER: begin
          rem_r <= rem_nxt;
          mag_r <= {mag_r[WIDE_W-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          result_r <= result_nxt;
          done_r   <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign done   = done_r;
  assign result = result_r;

  // The partial remainder never reaches the span while the loop runs.
  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ITER) |-> ({1'b0, rem_r} < span_r))
    else $error("remainder reached the span");

  // A finished result only follows the fix-up step.
  a_done_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r == S_FIX))
    else $error("done raised outside the fix-up step");

endmodule

// ===== rtl/bounded_stepper_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_stepper_unit: bounded up/down stepper
// Holds a signed 32-bit value and a signed step size and answers read, set,
// move and set-step words, bounding against a clamp or an inclusive wrap range.
// ----------------------------------------------------------------------------
// The stepper takes one word at a time on the in_ stream: in_tuser selects
// the operation and in_tdata carries the signed operand. A read returns the
// held value bounded against the current range, a set stores the bounded
// operand, a move adds operand times step (exact 64-bit product) and stores
// and returns the bounded sum, and a set-step replaces the step size. Read and
// move produce one out_ word, set and set-step produce none. A set-step is
// done as it is taken. A read or set passes the bound and retire steps, and
// a move first passes multiply and add steps. In wrap mode every bound goes
// through a serial remainder unit that retires one bit of a 64-bit dividend
// per cycle, and that loop sets the rate of words. in_tready is low while a
// word is in work. A finished result waits in an output register, so the next
// word is taken while the previous result is still unclaimed; a further result
// waits in the sequencer, with in_tready low, until that register is free.
// The range ends may be written in either order; the smaller acts as the lower
// end. Write the cfg_ registers only while the block is idle.
// ----------------------------------------------------------------------------
module bounded_stepper_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bs_pkg::VAL_W-1:0]          in_tdata,   // [31:0] operand
  input  logic [bs_pkg::OP_W-1:0]           in_tuser,   // [1:0] operation
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bs_pkg::VAL_W-1:0]          out_tdata,  // [31:0] out_value
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [bs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bs_pkg::VAL_W-1:0]          cfg_wdata
);
  import bs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_BOUND, ST_WRAP, ST_DONE
  } state_t;

  // Configuration registers.
  logic signed [VAL_W-1:0]  range_min_r;
  logic signed [VAL_W-1:0]  range_max_r;
  logic                     wrap_r;

  // Sequencer state, architectural state and work registers.
  state_t                   state_r;
  logic signed [VAL_W-1:0]  held_r;
  logic signed [VAL_W-1:0]  step_r;
  op_t                      op_r;
  logic signed [VAL_W-1:0]  arg_r;
  logic signed [WIDE_W-1:0] prod_r;
  logic signed [VAL_W-1:0]  base_r;
  logic signed [WIDE_W-1:0] sum_r;
  logic signed [VAL_W-1:0]  res_r;
  logic                     out_valid_r;
  logic [VAL_W-1:0]         out_data_r;

  logic signed [VAL_W-1:0]  lo;
  logic signed [VAL_W-1:0]  hi;
  logic [SPAN_W-1:0]        span;
  logic signed [WIDE_W-1:0] prod_nxt;
  logic signed [VAL_W-1:0]  held_clamp;
  logic signed [VAL_W-1:0]  sum_clamp;
  logic                     emit;
  logic                     retire;
  logic                     in_fire;
  logic                     mod_start;
  logic                     mod_done;
  logic signed [VAL_W-1:0]  mod_result;

  // Order the range ends; the span hi - lo + 1 lies between 1 and 2^32.
  always_comb begin
    if (range_min_r > range_max_r) begin
      lo = range_max_r;
      hi = range_min_r;
    end else begin
      lo = range_min_r;
      hi = range_max_r;
    end
  end

  assign span = {hi[VAL_W-1], hi} - {lo[VAL_W-1], lo} + SPAN_W'(1);

  // The 32x32 product is registered before the sum that follows it.
  assign prod_nxt = arg_r * step_r;

  // Clamp the held value; in wrap mode the held value is used as is, since
  // wrapping the sum later gives the same answer as wrapping both parts.
  always_comb begin
    if (held_r < lo) begin
      held_clamp = lo;
    end else if (held_r > hi) begin
      held_clamp = hi;
    end else begin
      held_clamp = held_r;
    end
  end

  always_comb begin
    if (sum_r < WIDE_W'(lo)) begin
      sum_clamp = lo;
    end else if (sum_r > WIDE_W'(hi)) begin
      sum_clamp = hi;
    end else begin
      sum_clamp = sum_r[VAL_W-1:0];
    end
  end

  assign emit      = (op_r == OP_READ) || (op_r == OP_MOVE);
  // The word in the retire step leaves unless its result finds the slot full and unclaimed.
  assign retire    = (state_r == ST_DONE) && (!emit || !out_valid_r || out_tready);
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign mod_start = (state_r == ST_BOUND) && wrap_r;

  bs_mod_unit u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .value  (sum_r),
    .lo     (lo),
    .span   (span),
    .done   (mod_done),
    .result (mod_result)
  );

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= INT_MIN;
      range_max_r <= INT_MAX;
      wrap_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RANGE_MIN: range_min_r <= cfg_wdata;
        REG_RANGE_MAX: range_max_r <= cfg_wdata;
        REG_WRAP_MODE: wrap_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer with the held value, step size and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      step_r      <= VAL_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      // A new result may refill the slot in the same cycle it is claimed.
      if (retire && emit) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_r;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            op_r  <= op_t'(in_tuser);
            arg_r <= in_tdata;
            unique case (op_t'(in_tuser))
              OP_READ: begin
                sum_r   <= WIDE_W'(held_r);
                state_r <= ST_BOUND;
              end
              OP_SET: begin
                sum_r   <= WIDE_W'($signed(in_tdata));
                state_r <= ST_BOUND;
              end
              OP_MOVE: begin
                state_r <= ST_MUL;
              end
              default: begin
                step_r <= in_tdata;
              end
            endcase
          end
        end
        ST_MUL: begin
          prod_r  <= prod_nxt;
          base_r  <= wrap_r ? held_r : held_clamp;
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          sum_r   <= WIDE_W'(base_r) + prod_r;
          state_r <= ST_BOUND;
        end
        ST_BOUND: begin
          if (wrap_r) begin
            state_r <= ST_WRAP;
          end else begin
            res_r   <= sum_clamp;
            state_r <= ST_DONE;
          end
        end
        ST_WRAP: begin
          if (mod_done) begin
            res_r   <= mod_result;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold here only while a result must go out and the slot is full and not claimed.
          if (retire) begin
            if (op_r != OP_READ) begin
              held_r <= res_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A new result appears only as the sequencer retires a word.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the retire step");

  // The remainder unit finishes only while the sequencer waits for it.
  a_mod_done_in_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == ST_WRAP))
    else $error("remainder unit finished while not awaited");

  // Every word other than set-step keeps the block busy for a while.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_tuser != OP_STEP)) |=> !in_tready)
    else $error("block ready right after taking a word with work");

endmodule

// ===== tb/bounded_stepper_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_stepper_unit_test: self-checking bench for the bounded stepper
// A directed table walks reset state, range extremes, reversed and single-point
// ranges, clamp and wrap bounding and an ignored register write. Random phases
// then run under many range settings. Every returned word is checked against
// an in-bench model of the stepper, with random idling on both streams.
// ----------------------------------------------------------------------------
module bounded_stepper_unit_test;
  import bs_pkg::*;

  // The cycle budget covers about 1100 words at the wrap-mode rate plus every
  // idle burst, the long output hold-off and the quiet time between phases,
  // with plenty of margin on top.
  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 100;   // longer than a wrap-mode move
  localparam int HOLD_CYCLES   = 400;   // long output hold-off
  localparam int NUM_PHASES    = 11;
  localparam int WORDS_PER_PHASE = 100;

  // The register list ends at index 2; index 3 is a spare that must be ignored.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

  typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

  // One line of the directed table: either a stream word or a register write.
  // Where fixed is set, the returned value is typed into the table.
  typedef struct {
    row_kind_t             kind;
    op_t                   op;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [VAL_W-1:0]      data;
    bit                    fixed;
    logic [VAL_W-1:0]      fixed_val;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [VAL_W-1:0]      in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [VAL_W-1:0]      out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [VAL_W-1:0]      cfg_wdata;

  // Bench copy of the stepper: the raw range registers, the mode, the held
  // value and the step size, all at the widths of the block.
  logic signed [VAL_W-1:0] range_lo_reg;
  logic signed [VAL_W-1:0] range_hi_reg;
  bit                      wrap_on;
  logic signed [VAL_W-1:0] held_now;
  logic signed [VAL_W-1:0] step_now;

  // Values the block still owes on the out_ stream, oldest first.
  logic [VAL_W-1:0] owed_values[$];
  stim_row_t        stim_rows[$];

  int error_count;
  bit steady_flow;     // no idling on either side when set
  bit hold_request;    // asks the receiver for one long hold-off

  bounded_stepper_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #CLK_HALF clk = ~clk;
    end
  end

  // A run that never drains ends here as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  // Bound a wide value against the current range. The two range registers
  // form an ordered pair whichever way round they were written. Clamp mode
  // saturates; wrap mode is inclusive at both ends, so the span runs from 1
  // up to 2^32 and the remainder is folded to be non-negative.
  function automatic longint bound_to_range(input longint v);
    longint lo;
    longint hi;
    longint span;
    longint off;
    lo = range_lo_reg;
    hi = range_hi_reg;
    if (lo > hi) begin
      span = lo;
      lo = hi;
      hi = span;
    end
    if (!wrap_on) begin
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    end
    span = (hi - lo) + 1;
    off = (v - lo) % span;
    if (off < 0) off += span;
    return lo + off;
  endfunction

  // Advance the bench copy of the stepper by one accepted word and, for a
  // read or a move, queue the value the block owes. A table row with a typed
  // value queues that value instead, while the state still advances.
  task automatic track_word(input op_t op, input logic [VAL_W-1:0] arg,
                            input bit fixed, input logic [VAL_W-1:0] fixed_val);
    longint           wide_sum;
    logic [VAL_W-1:0] result;
    bit               emits;
    emits = 1'b0;
    result = '0;
    case (op)
      OP_READ: begin
        result = VAL_W'(bound_to_range(held_now));
        emits = 1'b1;
      end
      OP_SET: begin
        held_now = VAL_W'(bound_to_range(longint'($signed(arg))));
      end
      OP_MOVE: begin
        // The product of two 32-bit signed values always fits in 64 bits.
        wide_sum = bound_to_range(held_now)
                 + longint'($signed(arg)) * longint'(step_now);
        held_now = VAL_W'(bound_to_range(wide_sum));
        result = VAL_W'(bound_to_range(held_now));
        emits = 1'b1;
      end
      default: begin
        step_now = arg;
      end
    endcase
    if (emits) owed_values.push_back(fixed ? fixed_val : result);
  endtask

  // Offer one word on the in_ stream and hold it until the block takes it.
  // A random idle burst may come first unless the flow is steady. The valid
  // line stays high from one word to the next when there is no burst.
  task automatic send_word(input op_t op, input logic [VAL_W-1:0] arg,
                           input bit fixed, input logic [VAL_W-1:0] fixed_val);
    int gap;
    if (!steady_flow && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = arg;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_word(op, arg, fixed, fixed_val);
  endtask

  // Let the block go idle: every owed value returned, then time for any
  // silent set still in the remainder loop to finish.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (owed_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register on the plain write port and mirror it in the bench
  // copy. The spare index changes nothing.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [VAL_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = data;
    case (idx)
      REG_RANGE_MIN: range_lo_reg = data;
      REG_RANGE_MAX: range_hi_reg = data;
      REG_WRAP_MODE: wrap_on = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Operand mix that reaches the interesting places: fully random bits,
  // small signed values, the ends of the 32-bit range and the ends of the
  // current bounding range.
  function automatic logic [VAL_W-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return VAL_W'($urandom_range(0, 40) - 20);
      3:    return INT_MIN + VAL_W'($urandom_range(0, 3));
      4:    return INT_MAX - VAL_W'($urandom_range(0, 3));
      default: begin
        if ($urandom_range(0, 1) == 0) return range_lo_reg + VAL_W'($urandom_range(0, 6)) - 3;
        return range_hi_reg + VAL_W'($urandom_range(0, 6)) - 3;
      end
    endcase
  endfunction

  // Counts and steps are mostly small so that moves walk along the range
  // and cross its ends often instead of always saturating.
  function automatic logic [VAL_W-1:0] pick_small();
    if ($urandom_range(0, 9) < 7) return VAL_W'($urandom_range(0, 8) - 4);
    return pick_operand();
  endfunction

  // Receiver: random stall bursts, one long hold-off on request, and a
  // steady ready in the quiet part of the run.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Every word taken from the out_ stream must match the oldest owed value.
  always @(posedge clk) begin
    logic [VAL_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_values.size() == 0) begin
        $display("%0t: unexpected out word, expected none, actual %h", $time, out_tdata);
        error_count++;
      end else begin
        want = owed_values.pop_front();
        if (out_tdata !== want) begin
          $display("%0t: out_value mismatch, expected %h, actual %h",
                   $time, want, out_tdata);
          error_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t        row;
    logic [VAL_W-1:0] arg;
    int               pick;
    op_t              op;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_READ;
    cfg_we       = 1'b0;
    cfg_addr     = REG_RANGE_MIN;
    cfg_wdata    = '0;
    error_count  = 0;
    steady_flow  = 1'b0;
    hold_request = 1'b0;

    // Reset state of the stepper.
    range_lo_reg = INT_MIN;
    range_hi_reg = INT_MAX;
    wrap_on      = 1'b0;
    held_now     = '0;
    step_now     = 32'sd1;

    // Directed table. Under the reset range the value starts at zero with a
    // step of one; extreme products must saturate cleanly in clamp mode.
    stim_rows.push_back('{ROW_WORD, OP_READ, REG_RANGE_MIN, 32'd0, 1'b1, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_MOVE, REG_RANGE_MIN, 32'd5, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_STEP, REG_RANGE_MIN, INT_MIN, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_MOVE, REG_RANGE_MIN, INT_MIN, 1'b1, INT_MAX});
    stim_rows.push_back('{ROW_WORD, OP_MOVE, REG_RANGE_MIN, INT_MAX, 1'b1, INT_MIN});
    // A zero step leaves the value in place and still returns it.
    stim_rows.push_back('{ROW_WORD, OP_STEP, REG_RANGE_MIN, 32'd0, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_MOVE, REG_RANGE_MIN, 32'h1234_5678, 1'b1, INT_MIN});
    // A negative step turns the direction of a move around.
    stim_rows.push_back('{ROW_WORD, OP_STEP, REG_RANGE_MIN, 32'hFFFF_FFFF, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_MOVE, REG_RANGE_MIN, 32'hFFFF_FFFD, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_SET, REG_RANGE_MIN, INT_MAX, 1'b0, 32'd0});
    // The operand of a read is ignored.
    stim_rows.push_back('{ROW_WORD, OP_READ, REG_RANGE_MIN, 32'hFFFF_FFFF, 1'b1, INT_MAX});
    // A reversed range bounds against the swapped pair, and a value left
    // outside the new range is re-bounded on the next read.
    stim_rows.push_back('{ROW_CFG, OP_READ, REG_RANGE_MIN, 32'd100, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_CFG, OP_READ, REG_RANGE_MAX, 32'hFFFF_FF9C, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_READ, REG_RANGE_MIN, 32'd0, 1'b1, 32'd100});
    // Wrap mode over -100..100: one past either end comes round to the other.
    stim_rows.push_back('{ROW_CFG, OP_READ, REG_WRAP_MODE, 32'd1, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_READ, REG_RANGE_MIN, 32'd0, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_STEP, REG_RANGE_MIN, 32'd1, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_SET, REG_RANGE_MIN, 32'd101, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_READ, REG_RANGE_MIN, 32'd0, 1'b1, 32'hFFFF_FF9C});
    stim_rows.push_back('{ROW_WORD, OP_MOVE, REG_RANGE_MIN, 32'hFFFF_FFFF, 1'b1, 32'd100});
    // A write to the spare index must leave every register alone.
    stim_rows.push_back('{ROW_CFG, OP_READ, REG_SPARE, 32'h0000_0000, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_READ, REG_RANGE_MIN, 32'd0, 1'b1, 32'd100});
    // A single-point range leaves only one legal value.
    stim_rows.push_back('{ROW_CFG, OP_READ, REG_RANGE_MIN, 32'd7, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_CFG, OP_READ, REG_RANGE_MAX, 32'd7, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_MOVE, REG_RANGE_MIN, 32'd0, 1'b1, 32'd7});
    // Full 32-bit range in wrap mode: the span is 2^32 and huge products
    // must fold back correctly.
    stim_rows.push_back('{ROW_CFG, OP_READ, REG_RANGE_MIN, INT_MIN, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_CFG, OP_READ, REG_RANGE_MAX, INT_MAX, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_STEP, REG_RANGE_MIN, INT_MAX, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_MOVE, REG_RANGE_MIN, INT_MAX, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_SET, REG_RANGE_MIN, INT_MIN, 1'b0, 32'd0});
    stim_rows.push_back('{ROW_WORD, OP_MOVE, REG_RANGE_MIN, 32'hFFFF_FFFF, 1'b0, 32'd0});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the table. A register row always waits for the block to go idle
    // first, since the range must not move under a word in work.
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.reg_idx, row.data);
      end else begin
        send_word(row.op, row.data, row.fixed, row.fixed_val);
      end
    end

    // Random phases, each under its own range setting. The first phases pin
    // the extremes; the rest draw ranges that are often small so that wraps
    // and clamps happen all the time. Every register is written each phase.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(REG_RANGE_MIN, INT_MIN);
          write_reg(REG_RANGE_MAX, INT_MAX);
          write_reg(REG_WRAP_MODE, 32'd0);
        end
        1: begin
          write_reg(REG_RANGE_MIN, INT_MIN);
          write_reg(REG_RANGE_MAX, INT_MAX);
          write_reg(REG_WRAP_MODE, 32'd1);
        end
        2: begin
          write_reg(REG_RANGE_MIN, INT_MAX);
          write_reg(REG_RANGE_MAX, INT_MIN);
          write_reg(REG_WRAP_MODE, 32'd1);
        end
        3: begin
          arg = pick_operand();
          write_reg(REG_RANGE_MIN, arg);
          write_reg(REG_RANGE_MAX, arg);
          write_reg(REG_WRAP_MODE, 32'($urandom_range(0, 1)));
        end
        4: begin
          write_reg(REG_RANGE_MIN, 32'd50);
          write_reg(REG_RANGE_MAX, 32'hFFFF_FFCE);
          write_reg(REG_WRAP_MODE, 32'hFFFF_FFFE);
        end
        default: begin
          write_reg(REG_RANGE_MIN, pick_operand());
          write_reg(REG_RANGE_MAX, pick_operand());
          write_reg(REG_WRAP_MODE, $urandom);
          if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, $urandom);
        end
      endcase

      // The clamp phase is fast, so a long output hold-off there fills the
      // block and forces in_tready low while words keep being offered.
      if (phase == 0) hold_request = 1'b1;
      // The last phase runs with both sides always ready.
      if (phase == NUM_PHASES - 1) steady_flow = 1'b1;

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          op = OP_READ;
          arg = $urandom;
        end else if (pick < 40) begin
          op = OP_SET;
          arg = pick_operand();
        end else if (pick < 85) begin
          op = OP_MOVE;
          arg = pick_small();
        end else begin
          op = OP_STEP;
          arg = pick_small();
        end
        send_word(op, arg, 1'b0, '0);
      end
    end

    settle();
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
